### rtl/core/sbh_pkg.sv
// Shared types, constant tables and the LPS transform of the Streebog hash engine.
package sbh_pkg;

  localparam int unsigned ROUNDS = 12;
  localparam int unsigned LAST_STEP = 2 * ROUNDS;
  localparam int unsigned STEP_W = $clog2(LAST_STEP + 1);
  localparam int unsigned RND_W = $clog2(ROUNDS);

  typedef logic [7:0][63:0] blk_t;
  typedef logic [63:0] lin_t [64];

  typedef struct packed {
    logic [63:0] word;
    logic        last;
    logic [2:0]  tail;
  } q_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_COMP,
    BK_OUT
  } bk_state_e;

  typedef enum logic [1:0] {
    PH_BLOCK,
    PH_LEN,
    PH_SUM
  } phase_e;

  localparam logic [7:0] SBOX [256] = '{
    8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,
    8'd251,8'd196,8'd250,8'd218,8'd35,8'd197,8'd4,8'd77,
    8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,
    8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,
    8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,
    8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
    8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,
    8'd6,8'd11,8'd237,8'd152,8'd127,8'd212,8'd211,8'd31,
    8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,
    8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,
    8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,
    8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
    8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,
    8'd243,8'd145,8'd120,8'd111,8'd157,8'd158,8'd178,8'd177,
    8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,
    8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,
    8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,
    8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
    8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,
    8'd220,8'd232,8'd40,8'd80,8'd78,8'd51,8'd10,8'd74,
    8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,
    8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,
    8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,
    8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
    8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,
    8'd48,8'd55,8'd107,8'd228,8'd136,8'd217,8'd231,8'd137,
    8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,
    8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,
    8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,
    8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
    8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,
    8'd209,8'd102,8'd175,8'd194,8'd57,8'd75,8'd99,8'd182
  };

  localparam logic [63:0] LIN_SEED [8] = '{
    64'h8e20faa72ba0b470, 64'ha011d380818e8f40, 64'h90dab52a387ae76f,
    64'h9d4df05d5f661451, 64'h86275df09ce8aaa8, 64'h456c34887a3805b9,
    64'he4fa2054a80b329c, 64'h70a6a56e2440598e
  };

  localparam logic [63:0] RC [12][8] = '{
    '{64'hdd806559f2a64507,64'h05767436cc744d23,64'ha2422a08a460d315,64'h4b7ce09192676901,
      64'h714eb88d7585c4fc,64'h2f6a76432e45d016,64'hebcb2f81c0657c1f,64'hb1085bda1ecadae9},
    '{64'he679047021b19bb7,64'h55dda21bd7cbcd56,64'h5cb561c2db0aa7ca,64'h9ab5176b12d69958,
      64'h61d55e0f16b50131,64'hf3feea720a232b98,64'h4fe39d460f70b5d7,64'h6fa3b58aa99d2f1a},
    '{64'h991e96f50aba0ab2,64'hc2b6f443867adb31,64'hc1c93a376062db09,64'hd3e20fe490359eb1,
      64'hf2ea7514b1297b7b,64'h06f15e5f529c1f8b,64'h0a39fc286a3d8435,64'hf574dcac2bce2fc7},
    '{64'h220cbebc84e3d12e,64'h3453eaa193e837f1,64'hd8b71333935203be,64'ha9d72c82ed03d675,
      64'h9d721cad685e353f,64'h488e857e335c3c7d,64'hf948e1a05d71e4dd,64'hef1fdfb3e81566d2},
    '{64'h601758fd7c6cfe57,64'h7a56a27ea9ea63f5,64'hdfff00b723271a16,64'hbfcd1747253af5a3,
      64'h359e35d7800fffbd,64'h7f151c1f1686104a,64'h9a3f410c6ca92363,64'h4bea6bacad474799},
    '{64'hfa68407a46647d6e,64'hbf71c57236904f35,64'h0af21f66c2bec6b6,64'hcffaa6b71c9ab7b4,
      64'h187f9ab49af08ec6,64'h2d66c4f95142a46c,64'h6fa4c33b7a3039c0,64'hae4faeae1d3ad3d9},
    '{64'h8886564d3a14d493,64'h3517454ca23c4af3,64'h06476983284a0504,64'h0992abc52d822c37,
      64'hd3473e33197a93c9,64'h399ec6c7e6bf87c9,64'h51ac86febf240954,64'hf4c70e16eeaac5ec},
    '{64'ha47f0dd4bf02e71e,64'h36acc2355951a8d9,64'h69d18d2bd1a5c42f,64'hf4892bcb929b0690,
      64'h89b4443b4ddbc49a,64'h4eb7f8719c36de1e,64'h03e7aa020c6e4141,64'h9b1f5b424d93c9a7},
    '{64'h7261445183235adb,64'h0e38dc92cb1f2a60,64'h7b2b8a9aa6079c54,64'h800a440bdbb2ceb1,
      64'h3cd955b7e00d0984,64'h3a7d3a1b25894224,64'h944c9ad8ec165fde,64'h378f5a541631229b},
    '{64'h74b4c7fb98459ced,64'h3698fad1153bb6c3,64'h7a1e6c303b7652f4,64'h9fe76702af69334b,
      64'h1fffe18a1b336103,64'h8941e71cff8a78db,64'h382ae548b2e4f3f3,64'habbedea680056f52},
    '{64'h6bcaa4cd81f32d1b,64'hdea2594ac06fd85d,64'hefbacd1d7d476e98,64'h8a1d71efea48b9ca,
      64'h2001802114846679,64'hd8fa6bbbebab0761,64'h3002c6cd635afe94,64'h7bcd9ed0efc889fb},
    '{64'h48bc924af11bd720,64'hfaf417d5d9b21b99,64'he71da4aa88e12852,64'h5d80ef9d1891cc86,
      64'hf82012d430219f9b,64'hcda43c32bcdf1d77,64'hd21380b00449b17a,64'h378ee767f11631ba}
  };

  // Linear map rows: each byte is the byte above shifted right, xor 8'h8e if odd.
  function automatic lin_t build_lin();
    lin_t        lin;
    logic [63:0] x;
    logic [7:0]  b;
    for (int g = 0; g < 8; g++) begin
      x = LIN_SEED[g];
      for (int r = 0; r < 8; r++) begin
        lin[g * 8 + r] = x;
        for (int k = 0; k < 8; k++) begin
          b = x[8 * k +: 8];
          x[8 * k +: 8] = {1'b0, b[7:1]} ^ (b[0] ? 8'h8e : 8'h00);
        end
      end
    end
    return lin;
  endfunction

  localparam lin_t LIN = build_lin();

  function automatic logic [63:0] lps_entry(logic [2:0] pos, logic [7:0] v);
    logic [63:0] t;
    logic [7:0]  p;
    t = '0;
    p = SBOX[v];
    for (int k = 0; k < 8; k++) begin
      if (p[k]) t ^= LIN[{~pos, ~3'(k)}];
    end
    return t;
  endfunction

  function automatic blk_t lps(blk_t x);
    blk_t y;
    for (int i = 0; i < 8; i++) begin
      y[i] = '0;
      for (int j = 0; j < 8; j++) begin
        y[i] ^= lps_entry(3'(j), x[j][8 * i +: 8]);
      end
    end
    return y;
  endfunction

endpackage

### rtl/core/sbh_front.sv
// Front end: saturates byte counts, packs message bytes into 64-bit words, pads the tail.
module sbh_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               flush_i,
  input  logic               push_i,
  output logic               full_o,
  input  logic [63:0]        data_word_i,
  input  logic [3:0]         byte_count_i,
  input  logic               final_req_i,
  output logic               q_push_o,
  output sbh_pkg::q_entry_t  q_entry_o,
  input  logic               q_full_i
);

  sbh_pkg::q_entry_t e0_q, e1_q, new_e0, new_e1;
  logic              v0_q, v1_q, new_v0, new_v1;
  logic [63:0]       part_q;
  logic [2:0]        pcnt_q;
  logic [3:0]        cnt, tot;
  logic [63:0]       mask;
  logic [127:0]      comb;
  logic              drain, accept;

  always_comb begin
    cnt    = (byte_count_i > 4'd8) ? 4'd8 : byte_count_i;
    mask   = cnt[3] ? '1 : ((64'd1 << {cnt[2:0], 3'b000}) - 64'd1);
    comb   = {64'd0, part_q} | ({64'd0, data_word_i & mask} << {pcnt_q, 3'b000});
    tot    = {1'b0, pcnt_q} + cnt;
    drain  = v0_q && !q_full_i;
    full_o = !(!v0_q || (drain && !v1_q));
    accept = push_i && !full_o;

    // a full word goes out first; the padded remainder follows on final
    new_v0        = tot[3] || final_req_i;
    new_e0.word   = tot[3] ? comb[63:0] : (comb[63:0] | (64'd1 << {tot[2:0], 3'b000}));
    new_e0.last   = !tot[3] && final_req_i;
    new_e0.tail   = tot[2:0];
    new_v1        = tot[3] && final_req_i;
    new_e1.word   = comb[127:64] | (64'd1 << {tot[2:0], 3'b000});
    new_e1.last   = 1'b1;
    new_e1.tail   = tot[2:0];
  end

  assign q_push_o  = drain;
  assign q_entry_o = e0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      part_q <= '0;
      pcnt_q <= '0;
    end else if (flush_i) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      part_q <= '0;
      pcnt_q <= '0;
    end else if (accept) begin
      v0_q   <= new_v0;
      v1_q   <= new_v1;
      part_q <= final_req_i ? 64'd0 : (tot[3] ? comb[127:64] : comb[63:0]);
      pcnt_q <= final_req_i ? 3'd0 : tot[2:0];
    end else if (drain) begin
      v0_q <= v1_q;
      v1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      e0_q <= new_e0;
      e1_q <= new_e1;
    end else if (drain) begin
      e0_q <= e1_q;
    end
  end

endmodule

### rtl/core/sbh_fifo.sv
// Small word queue between the packing front end and the compression back end.
module sbh_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               flush_i,
  input  logic               push_i,
  input  sbh_pkg::q_entry_t  entry_i,
  output logic               full_o,
  input  logic               pop_i,
  output sbh_pkg::q_entry_t  entry_o,
  output logic               valid_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sbh_pkg::q_entry_t mem_q [DEPTH];
  logic [PW-1:0]     wptr_q, rptr_q;
  logic [PW:0]       count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (PW+1)'(DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else if (flush_i) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      if (do_pop)  rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      count_q <= count_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= entry_i;
  end

endmodule

### rtl/core/sbh_back.sv
// Back end: block assembly, g_N compression, length and checksum sums, digest readout.
module sbh_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_data_i,
  input  logic               q_valid_i,
  input  sbh_pkg::q_entry_t  q_entry_i,
  output logic               q_pop_o,
  output logic               empty_o,
  input  logic               pop_i,
  output logic [63:0]        digest_word_o,
  output logic [2:0]         word_index_o,
  output logic               last_word_o
);

  sbh_pkg::bk_state_e state_q, state_d;
  sbh_pkg::phase_e    phase_q;
  sbh_pkg::blk_t      h_q, n_q, sig_q, blk_q, k_q, s_q;
  sbh_pkg::blk_t      m_sel, n_sel, rc_row, lps_in, lps_out;
  logic [sbh_pkg::STEP_W-1:0] step_q;
  logic [sbh_pkg::RND_W-1:0]  rnd_q;
  logic [9:0]         inc_q;
  logic [2:0]         wcnt_q, oidx_q, wi;
  logic               fin_q, d256_q, cs_q, cn_q, cin_s, cin_n;
  logic               take, start, comp_done, last_out, add_en;
  logic [64:0]        sum_s, sum_n;
  logic [63:0]        start_word;

  always_comb begin
    take      = (state_q == sbh_pkg::BK_IDLE) && q_valid_i;
    start     = take && (q_entry_i.last || (wcnt_q == 3'd7));
    comp_done = (state_q == sbh_pkg::BK_COMP) &&
                (step_q == sbh_pkg::STEP_W'(sbh_pkg::LAST_STEP));
    last_out  = d256_q ? (oidx_q == 3'd3) : (oidx_q == 3'd7);
    state_d   = state_q;
    unique case (state_q)
      sbh_pkg::BK_IDLE: if (start) state_d = sbh_pkg::BK_COMP;
      sbh_pkg::BK_COMP: begin
        if (comp_done && phase_q == sbh_pkg::PH_SUM) state_d = sbh_pkg::BK_OUT;
        else if (comp_done && phase_q == sbh_pkg::PH_BLOCK && !fin_q)
          state_d = sbh_pkg::BK_IDLE;
      end
      sbh_pkg::BK_OUT: if (pop_i && last_out) state_d = sbh_pkg::BK_IDLE;
      default: state_d = sbh_pkg::BK_IDLE;
    endcase
    if (cfg_we_i) state_d = sbh_pkg::BK_IDLE;
  end

  assign q_pop_o       = take;
  assign empty_o       = (state_q != sbh_pkg::BK_OUT);
  assign digest_word_o = h_q[{oidx_q[2] | d256_q, oidx_q[1:0]}];
  assign word_index_o  = oidx_q;
  assign last_word_o   = last_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= sbh_pkg::BK_IDLE;
    else         state_q <= state_d;
  end

  // round datapath: one full LPS per cycle, shared by key and state
  always_comb begin
    unique case (phase_q)
      sbh_pkg::PH_LEN: m_sel = n_q;
      sbh_pkg::PH_SUM: m_sel = sig_q;
      default:         m_sel = blk_q;
    endcase
    n_sel = (phase_q == sbh_pkg::PH_BLOCK) ? n_q : '0;
    for (int w = 0; w < 8; w++) rc_row[w] = sbh_pkg::RC[rnd_q][w];
    if (step_q == '0)   lps_in = h_q ^ n_sel;
    else if (step_q[0]) lps_in = s_q;
    else                lps_in = k_q ^ rc_row;
    lps_out = sbh_pkg::lps(lps_in);

    // word-serial sums during the first eight steps of a message block
    wi     = step_q[2:0];
    add_en = (state_q == sbh_pkg::BK_COMP) && (phase_q == sbh_pkg::PH_BLOCK) && (step_q < 8);
    cin_s  = (step_q == '0) ? 1'b0 : cs_q;
    cin_n  = (step_q == '0) ? 1'b0 : cn_q;
    sum_s  = {1'b0, sig_q[wi]} + {1'b0, blk_q[wi]} + 65'(cin_s);
    sum_n  = {1'b0, n_q[wi]} + ((wi == 3'd0) ? 65'(inc_q) : 65'd0) + 65'(cin_n);
    start_word = cfg_data_i ? 64'h0101010101010101 : 64'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d256_q  <= 1'b0;
      h_q     <= '0;
      n_q     <= '0;
      sig_q   <= '0;
      wcnt_q  <= '0;
      oidx_q  <= '0;
      step_q  <= '0;
      rnd_q   <= '0;
      phase_q <= sbh_pkg::PH_BLOCK;
      fin_q   <= 1'b0;
      inc_q   <= '0;
      cs_q    <= 1'b0;
      cn_q    <= 1'b0;
    end else if (cfg_we_i) begin
      d256_q  <= cfg_data_i;
      h_q     <= {8{start_word}};
      n_q     <= '0;
      sig_q   <= '0;
      wcnt_q  <= '0;
      oidx_q  <= '0;
      phase_q <= sbh_pkg::PH_BLOCK;
      fin_q   <= 1'b0;
    end else begin
      unique case (state_q)
        sbh_pkg::BK_IDLE: begin
          if (take) begin
            wcnt_q <= q_entry_i.last ? 3'd0 : wcnt_q + 1'b1;
            if (start) begin
              step_q  <= '0;
              rnd_q   <= '0;
              phase_q <= sbh_pkg::PH_BLOCK;
              fin_q   <= q_entry_i.last;
              inc_q   <= q_entry_i.last ? {1'b0, wcnt_q, q_entry_i.tail, 3'b000} : 10'd512;
            end
          end
        end
        sbh_pkg::BK_COMP: begin
          if (add_en) begin
            sig_q[wi] <= sum_s[63:0];
            n_q[wi]   <= sum_n[63:0];
            cs_q      <= sum_s[64];
            cn_q      <= sum_n[64];
          end
          if (step_q != '0 && !step_q[0]) rnd_q <= rnd_q + 1'b1;
          if (comp_done) begin
            h_q    <= h_q ^ s_q ^ lps_out ^ m_sel;
            step_q <= '0;
            rnd_q  <= '0;
            oidx_q <= '0;
            if (phase_q == sbh_pkg::PH_BLOCK)    phase_q <= sbh_pkg::PH_LEN;
            else if (phase_q == sbh_pkg::PH_LEN) phase_q <= sbh_pkg::PH_SUM;
            else                                 phase_q <= sbh_pkg::PH_BLOCK;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        sbh_pkg::BK_OUT: begin
          if (pop_i) begin
            oidx_q <= oidx_q + 1'b1;
            if (last_out) begin
              h_q     <= {8{d256_q ? 64'h0101010101010101 : 64'd0}};
              n_q     <= '0;
              sig_q   <= '0;
              phase_q <= sbh_pkg::PH_BLOCK;
              fin_q   <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (q_entry_i.last) begin
        for (int w = 0; w < 8; w++) begin
          if (3'(w) == wcnt_q)     blk_q[w] <= q_entry_i.word;
          else if (3'(w) > wcnt_q) blk_q[w] <= '0;
        end
      end else begin
        blk_q[wcnt_q] <= q_entry_i.word;
      end
    end
    if (state_q == sbh_pkg::BK_COMP) begin
      if (step_q == '0) begin
        k_q <= lps_out;
        s_q <= lps_out ^ m_sel;
      end else if (step_q[0]) begin
        s_q <= lps_out;
      end else begin
        k_q <= lps_out;
        s_q <= s_q ^ lps_out;
      end
    end
  end

endmodule

### rtl/core/streebog_hash_engine.sv
// A full 64-byte block starts compressing once its eighth word is taken from the queue.
// Final item: padded block plus two closing compressions, then one digest word a cycle while pop is held.
// A block needs 8 word transfers and 25 LPS steps; words wait in the queue while the back end compresses.
// The LPS unit evaluates one full 512-bit LPS per cycle and sets the block rate.
// Reset (async, active low) clears the control and hash state; any cfg write restarts the message.
module streebog_hash_engine #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        final_req_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  sbh_pkg::q_entry_t f_entry, b_entry;
  logic              f_push, q_full, q_valid, b_pop;

  sbh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .flush_i      (cfg_we_i),
    .push_i       (push),
    .full_o       (full),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .final_req_i  (final_req_i),
    .q_push_o     (f_push),
    .q_entry_o    (f_entry),
    .q_full_i     (q_full)
  );

  sbh_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flush_i (cfg_we_i),
    .push_i  (f_push),
    .entry_i (f_entry),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .entry_o (b_entry),
    .valid_o (q_valid)
  );

  sbh_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .q_valid_i     (q_valid),
    .q_entry_i     (b_entry),
    .q_pop_o       (b_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

endmodule

### rtl/core/sbh_checker.sv
// Port-level checks on the digest readout, bound to the top level.
module sbh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [63:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);

  // digest words follow back to back until the last one
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && !last_word_o |=> !empty)
    else $error("digest burst broke before last word");

  a_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && !last_word_o |=> word_index_o == $past(word_index_o) + 3'd1)
    else $error("digest word index did not advance");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && last_word_o |=> empty)
    else $error("result shown after last digest word");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(digest_word_o))
    else $error("waiting digest word changed");

endmodule

bind streebog_hash_engine sbh_checker u_sbh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .digest_word_o (digest_word_o),
  .word_index_o  (word_index_o),
  .last_word_o   (last_word_o)
);

### verif/streebog_hash_engine_checker.sv
// Checker for the hash engine: watches transfers, predicts digests and compares them.
module streebog_hash_engine_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  input  logic        push,
  input  logic        full,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        final_req_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [63:0] digest_word_o,
  input  logic [2:0]  word_index_o,
  input  logic        last_word_o,
  output int          fail_count_o,
  output int          pending_o
);

  typedef logic [7:0][63:0] wide_t;

  typedef struct {
    logic [63:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  digest_word_t digest_q[$];
  logic [63:0]  lps_tab [8][256];
  logic         mode_256;
  wide_t        chain, msg_len, msg_sum;
  logic [7:0]   blk_bytes [64];
  int unsigned  fill;

  initial begin
    logic [63:0] lin [64];
    logic [63:0] x, t;
    logic [7:0]  p;
    for (int g = 0; g < 8; g++) begin
      x = sbh_pkg::LIN_SEED[g];
      for (int r = 0; r < 8; r++) begin
        lin[g * 8 + r] = x;
        x = ((x >> 1) & 64'h7f7f7f7f7f7f7f7f) ^ ((x & 64'h0101010101010101) * 64'h8e);
      end
    end
    for (int pos = 0; pos < 8; pos++) begin
      for (int v = 0; v < 256; v++) begin
        t = '0;
        p = sbh_pkg::SBOX[v];
        for (int k = 0; k < 8; k++) if (p[k]) t ^= lin[(7 - pos) * 8 + 7 - k];
        lps_tab[pos][v] = t;
      end
    end
  end

  function automatic wide_t lps_map(wide_t s);
    wide_t y;
    for (int i = 0; i < 8; i++) begin
      y[i] = '0;
      for (int j = 0; j < 8; j++) y[i] ^= lps_tab[j][s[j][8 * i +: 8]];
    end
    return y;
  endfunction

  task automatic compress(wide_t n, wide_t m);
    wide_t key, s;
    key = lps_map(chain ^ n);
    s = m ^ key;
    for (int r = 0; r < 12; r++) begin
      s = lps_map(s);
      for (int w = 0; w < 8; w++) key[w] ^= sbh_pkg::RC[r][w];
      key = lps_map(key);
      s ^= key;
    end
    chain ^= s ^ m;
  endtask

  function automatic wide_t block_value();
    wide_t m;
    for (int i = 0; i < 64; i++) m[i / 8][8 * (i % 8) +: 8] = blk_bytes[i];
    return m;
  endfunction

  task automatic restart_message();
    chain = mode_256 ? {8{64'h0101010101010101}} : '0;
    msg_len = '0;
    msg_sum = '0;
    fill = 0;
  endtask

  task automatic absorb_item(logic [63:0] data, logic [3:0] cnt, logic fin);
    int unsigned n, first;
    wide_t m;
    n = (cnt > 8) ? 8 : cnt;
    for (int b = 0; b < n; b++) begin
      blk_bytes[fill] = data[8 * b +: 8];
      fill++;
      if (fill == 64) begin
        m = block_value();
        compress(msg_len, m);
        msg_len += 512;
        msg_sum += m;
        fill = 0;
      end
    end
    if (fin) begin
      blk_bytes[fill] = 8'h01;
      for (int i = fill + 1; i < 64; i++) blk_bytes[i] = 8'h00;
      m = block_value();
      compress(msg_len, m);
      msg_len += fill * 8;
      msg_sum += m;
      compress('0, msg_len);
      compress('0, msg_sum);
      first = mode_256 ? 4 : 0;
      for (int j = 0; j < 8 - first; j++)
        digest_q.push_back('{chain[first + j], 3'(j), (j == 7 - first)});
      restart_message();
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    mode_256 = 1'b0;
    restart_message();
  end

  always @(posedge clk_i) begin
    digest_word_t exp_w;
    if (rst_ni) begin
      if (cfg_we_i) begin
        mode_256 = cfg_data_i;
        restart_message();
      end
      if (push && !full) absorb_item(data_word_i, byte_count_i, final_req_i);
      if (pop && !empty) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word %h idx %0d", $time, digest_word_o,
                   word_index_o);
          fail_count_o++;
        end else begin
          exp_w = digest_q.pop_front();
          if (digest_word_o !== exp_w.word || word_index_o !== exp_w.index ||
              last_word_o !== exp_w.last) begin
            $display("%0t: digest mismatch exp %h/%0d/%0b got %h/%0d/%0b", $time,
                     exp_w.word, exp_w.index, exp_w.last, digest_word_o, word_index_o,
                     last_word_o);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = digest_q.size();
  end

endmodule

### verif/tb.sv
// Testbench top for the hash engine: stimulus, receiver stalls and the verdict.
module tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_data_i = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [63:0] data_word_i = '0;
  logic [3:0]  byte_count_i = '0;
  logic        final_req_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [63:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;
  int          fail_count, pending;
  int          items_sent = 0, msgs_sent = 0, mode_writes = 0;
  int          hold_cycles = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  streebog_hash_engine dut (.*);

  streebog_hash_engine_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .push, .full, .data_word_i, .byte_count_i,
    .final_req_i, .empty, .pop, .digest_word_o, .word_index_o, .last_word_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random pops, long hold-offs at random and on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        pop <= 1'b0;
        hold_cycles--;
      end else if ($urandom_range(0, 99) < 3) begin
        hold_cycles = $urandom_range(10, 30);
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) < 75);
      end
    end
  end

  task automatic send_word(logic [63:0] data, logic [3:0] cnt, logic fin);
    int g;
    push <= 1'b1;
    data_word_i <= data;
    byte_count_i <= cnt;
    final_req_i <= fin;
    do @(posedge clk_i); while (full);
    items_sent++;
    if (fin) msgs_sent++;
    g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    if (push) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    while (pending != 0) @(posedge clk_i);
  endtask

  // Partial messages leave compression running with nothing expected: wait it out.
  task automatic write_mode(logic m);
    drain();
    repeat (150) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_writes++;
  endtask

  task automatic rand_message(int max_items);
    int n;
    logic [3:0] cnt;
    n = $urandom_range(0, max_items);
    for (int i = 0; i < n; i++) begin
      cnt = ($urandom_range(0, 3) != 0) ? 4'd8 : 4'($urandom_range(0, 15));
      send_word({$urandom, $urandom}, cnt, 1'b0);
    end
    send_word({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b1);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: empty message, one full word, saturated count, all-ones data
    send_word('0, 4'd0, 1'b1);
    send_word(64'h0706050403020100, 4'd8, 1'b1);
    send_word('1, 4'd15, 1'b1);
    // exactly one block, then an empty final
    for (int i = 0; i < 8; i++) send_word('1, 4'd8, 1'b0);
    send_word('0, 4'd0, 1'b1);
    // 63 bytes then final with a single byte filling the block
    for (int i = 0; i < 7; i++) send_word({$urandom, $urandom}, 4'd8, 1'b0);
    send_word(64'h00ffffffffffffff, 4'd7, 1'b0);
    send_word(64'hab, 4'd1, 1'b1);
    write_mode(1'b1);
    send_word('0, 4'd0, 1'b1);
    send_word('1, 4'd8, 1'b1);
    // abandoned message, then back to 512-bit mode
    send_word({$urandom, $urandom}, 4'd5, 1'b0);
    write_mode(1'b0);
    send_word(64'h1, 4'd9, 1'b1);
    write_mode(1'b1);
    write_mode(1'b0);

    // receiver holds off while the sender keeps going until the input stalls
    hold_cycles = 300;
    rand_message(3);
    for (int i = 0; i < 12; i++) send_word({$urandom, $urandom}, 4'd8, 1'b0);
    send_word({$urandom, $urandom}, 4'd8, 1'b1);
    rand_message(3);
    drain();

    while (items_sent < 290) begin
      rand_message(($urandom_range(0, 9) == 0) ? 24 : 10);
      if ($urandom_range(0, 9) == 0) write_mode(1'($urandom_range(0, 1)));
      else if ($urandom_range(0, 9) == 0) drain();
    end
    drain();
    repeat (150) @(posedge clk_i);
    $display("Sent %0d items in %0d messages with %0d mode writes.", items_sent,
             msgs_sent, mode_writes);
    $display("Covered empty, partial, block-aligned and abandoned messages in both modes.");
    if (fail_count == 0) $display("** streebog_hash_engine: PASSED **");
    else $display("** streebog_hash_engine: FAILED **");
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d digest words outstanding.", pending);
    $display("** streebog_hash_engine: FAILED **");
    $finish;
  end

endmodule

### files.f
rtl/core/sbh_pkg.sv
rtl/core/sbh_front.sv
rtl/core/sbh_fifo.sv
rtl/core/sbh_back.sv
rtl/core/streebog_hash_engine.sv
rtl/core/sbh_checker.sv
verif/streebog_hash_engine_checker.sv
verif/tb.sv
